// ===== hw/rtl/fpdq_pkg.sv =====
// ----------------------------------------------------------------------------
// fpdq_pkg
// shared types and constants of the signed fixed-point divider
// ----------------------------------------------------------------------------
`default_nettype none

package fpdq_pkg;

   // operand and result word width
   localparam int WORD_W = 32;

   // default number of fraction bits (16.16 format)
   localparam int FRAC_BITS_DEFAULT = 16;

   typedef struct packed {
      logic signed [WORD_W-1:0] dividend;
      logic signed [WORD_W-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] quotient;
      logic                     divide_by_zero;
      logic                     overflow;
   } rsp_type;

   // side information carried down the pipeline with each word
   typedef struct packed {
      logic negate;   // operand signs differ
      logic div_zero; // divisor magnitude is zero
   } stage_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fpdq_stage.sv =====
// ----------------------------------------------------------------------------
// fpdq_stage
// one restoring division step with its own pipeline register
// ----------------------------------------------------------------------------
`default_nettype none

module fpdq_stage
   import fpdq_pkg::*;
#(
   parameter int NUM_W = WORD_W + FRAC_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              prev_valid,
   output      logic              prev_ready,
   input  wire logic [WORD_W-1:0] prev_rem,
   input  wire logic [NUM_W-1:0]  prev_nq,
   input  wire logic [WORD_W-1:0] prev_mb,
   input  wire stage_ctl_type     prev_ctl,
   output      logic              next_valid,
   input  wire logic              next_ready,
   output      logic [WORD_W-1:0] next_rem,
   output      logic [NUM_W-1:0]  next_nq,
   output      logic [WORD_W-1:0] next_mb,
   output      stage_ctl_type     next_ctl
);

   logic              vld_ff;
   logic              vld_in;
   logic [WORD_W-1:0] rem_ff;
   logic [WORD_W-1:0] rem_in;
   logic [NUM_W-1:0]  nq_ff;
   logic [NUM_W-1:0]  nq_in;
   logic [WORD_W-1:0] mb_ff;
   stage_ctl_type     ctl_ff;
   logic [WORD_W:0]   rem_sh;
   logic [WORD_W+1:0] trial;
   logic              qbit;
   logic              load;

   // shift in the next numerator bit and try the subtract
   always_comb begin
      rem_sh = {prev_rem, prev_nq[NUM_W-1]};
      trial  = {1'b0, rem_sh} - {2'b00, prev_mb};
      qbit   = ~trial[WORD_W+1];
      rem_in = qbit ? trial[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      nq_in  = {prev_nq[NUM_W-2:0], qbit};
   end

   assign load       = ~vld_ff | next_ready;
   assign prev_ready = load;
   assign vld_in     = load ? prev_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && prev_valid) begin
         rem_ff <= rem_in;
         nq_ff  <= nq_in;
         mb_ff  <= prev_mb;
         ctl_ff <= prev_ctl;
      end
   end

   assign next_valid = vld_ff;
   assign next_rem   = rem_ff;
   assign next_nq    = nq_ff;
   assign next_mb    = mb_ff;
   assign next_ctl   = ctl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_point_divider_q16.sv =====
// ----------------------------------------------------------------------------
// fixed_point_divider_q16
// pipelined signed fixed-point divider, unless stalled one word per cycle
// ----------------------------------------------------------------------------
// Divides two signed fixed-point words (16.16 by default) and returns the
// quotient in the same format, truncated toward zero. A new word can be taken
// every cycle unless req_stall is high. The restoring divider resolves one
// quotient bit per pipeline stage, between an operand register in front and
// the result register behind. A zero divisor returns all ones with
// divide_by_zero set; a magnitude quotient of 2^31 or more sets overflow and
// the result wraps. Each stage holds its word until the next one can take
// it, so bubbles close up while the output is stalled.
`default_nettype none

module fixed_point_divider_q16
   import fpdq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_word,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_word
);

   // numerator width: dividend magnitude with the fraction shift applied
   localparam int NUM_W = WORD_W + FRAC_BITS;

   // pipeline links: index 0 is the operand register, index k the k-th step
   logic                vld   [0:NUM_W];
   logic                rdy   [1:NUM_W+1];
   logic [WORD_W-1:0]   rem   [0:NUM_W];
   logic [NUM_W-1:0]    nq    [0:NUM_W];
   logic [WORD_W-1:0]   mb    [0:NUM_W];
   stage_ctl_type       ctl   [0:NUM_W];

   // operand register
   logic                op_vld_ff;
   logic                op_vld_in;
   logic [WORD_W-1:0]   op_ma_ff;
   logic [WORD_W-1:0]   op_mb_ff;
   stage_ctl_type       op_ctl_ff;
   logic [WORD_W-1:0]   ma_in;
   logic [WORD_W-1:0]   mb_in;
   stage_ctl_type       ctl_in;
   logic                op_load;

   // result register
   logic                out_vld_ff;
   logic                out_vld_in;
   rsp_type             out_ff;
   rsp_type             out_in;
   logic [WORD_W-1:0]   quo_low;
   logic                quo_big;

   // magnitudes: the most negative value maps to 2^31, which still fits
   always_comb begin
      ma_in           = req_word.dividend[WORD_W-1] ? (-req_word.dividend)
                                                    : req_word.dividend;
      mb_in           = req_word.divisor[WORD_W-1]  ? (-req_word.divisor)
                                                    : req_word.divisor;
      ctl_in.negate   = req_word.dividend[WORD_W-1] ^ req_word.divisor[WORD_W-1];
      ctl_in.div_zero = (req_word.divisor == '0);
   end

   assign op_load   = ~op_vld_ff | rdy[1];
   assign req_stall = ~op_load;
   assign op_vld_in = op_load ? req_valid : op_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_vld_ff <= 1'b0;
      end else begin
         op_vld_ff <= op_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_load && req_valid) begin
         op_ma_ff  <= ma_in;
         op_mb_ff  <= mb_in;
         op_ctl_ff <= ctl_in;
      end
   end

   // the numerator and quotient share one shift register: numerator bits
   // leave at the top while quotient bits enter at the bottom
   assign vld[0] = op_vld_ff;
   assign rem[0] = '0;
   assign nq[0]  = {op_ma_ff, {FRAC_BITS{1'b0}}};
   assign mb[0]  = op_mb_ff;
   assign ctl[0] = op_ctl_ff;

   for (genvar k = 1; k <= NUM_W; k++) begin : g_step
      fpdq_stage #(
         .NUM_W (NUM_W)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (vld[k-1]),
         .prev_ready (rdy[k]),
         .prev_rem   (rem[k-1]),
         .prev_nq    (nq[k-1]),
         .prev_mb    (mb[k-1]),
         .prev_ctl   (ctl[k-1]),
         .next_valid (vld[k]),
         .next_ready (rdy[k+1]),
         .next_rem   (rem[k]),
         .next_nq    (nq[k]),
         .next_mb    (mb[k]),
         .next_ctl   (ctl[k])
      );
   end

   // the remainder and divisor of the last step are not needed further on

   // sign fix-up, overflow check and zero-divisor override
   always_comb begin
      quo_low = nq[NUM_W][WORD_W-1:0];
      quo_big = |nq[NUM_W][NUM_W-1:WORD_W-1];
      if (ctl[NUM_W].div_zero) begin
         out_in.quotient       = '1;
         out_in.divide_by_zero = 1'b1;
         out_in.overflow       = 1'b0;
      end else begin
         out_in.quotient       = ctl[NUM_W].negate ? (-quo_low) : quo_low;
         out_in.divide_by_zero = 1'b0;
         out_in.overflow       = quo_big;
      end
   end

   // output register frees as soon as its word is taken
   assign rdy[NUM_W+1] = ~out_vld_ff | ~rsp_stall;
   assign out_vld_in   = rdy[NUM_W+1] ? vld[NUM_W] : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NUM_W+1] && vld[NUM_W]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_fixed_point_divider_q16.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_divider_q16
// self-checking bench for the pipelined signed 16.16 divider
// ----------------------------------------------------------------------------
// A driver feeds operand words from a queue in random bursts, and the result
// side stalls in changing patterns. Every accepted word is run through a
// local model of the divide. Its expected result is queued and compared,
// field by field, with the next word that leaves the block.
// ----------------------------------------------------------------------------

module tb_fixed_point_divider_q16;
   import fpdq_pkg::*;

   localparam int FRAC        = FRAC_BITS_DEFAULT;
   localparam int LATENCY     = 32 + FRAC + 2;
   localparam int DRAIN       = LATENCY + 30;
   localparam int RANDOM_WORDS = 1900;
   localparam int CYCLE_LIMIT = 400000;

   // result side stall patterns
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   req_type pending_words[$];      // operand words still to be driven
   rsp_type expected_quotients[$]; // predicted results, oldest first

   logic           req_taken  = 1'b0;
   int             burst_left = 1;
   int             gap_left   = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   int cycle_count    = 0;
   int fail_count     = 0;
   int result_count   = 0;
   int zero_div_count = 0;
   int overflow_count = 0;
   int negative_count = 0;

   fixed_point_divider_q16 #(
      .FRAC_BITS (FRAC)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // signed divide on magnitudes, truncated, then sign corrected
   function automatic rsp_type divide_q16(req_type op);
      logic [WORD_W-1:0] raw_a;
      logic [WORD_W-1:0] raw_b;
      logic [WORD_W-1:0] mag_a;
      logic [WORD_W-1:0] mag_b;
      logic [63:0]       numer;
      logic [63:0]       quo;
      logic [WORD_W-1:0] low_word;
      rsp_type           r;
      raw_a = op.dividend;
      raw_b = op.divisor;
      // the most negative word negates to itself, read unsigned as 2^31
      mag_a = raw_a[WORD_W-1] ? (~raw_a + 1'b1) : raw_a;
      mag_b = raw_b[WORD_W-1] ? (~raw_b + 1'b1) : raw_b;
      r = '0;
      if (mag_b == '0) begin
         r.quotient       = '1;
         r.divide_by_zero = 1'b1;
         r.overflow       = 1'b0;
      end else begin
         numer = 64'(mag_a) << FRAC;
         quo   = numer / 64'(mag_b);
         low_word = quo[WORD_W-1:0];
         if (raw_a[WORD_W-1] != raw_b[WORD_W-1])
            low_word = ~low_word + 1'b1;
         r.quotient = low_word;
         r.overflow = (quo >= 64'h0000_0000_8000_0000);
      end
      return r;
   endfunction

   // operand of a random kind: full range, short magnitudes or an edge value
   function automatic logic [WORD_W-1:0] random_operand();
      logic [WORD_W-1:0] v;
      int                kind;
      kind = $urandom_range(0, 9);
      v    = $urandom;
      case (kind)
         0, 1: begin
            // full 32-bit pattern
         end
         2: begin
            case ($urandom_range(0, 6))
               0: v = 32'h0000_0000;
               1: v = 32'h0000_0001;
               2: v = 32'hFFFF_FFFF;
               3: v = 32'h7FFF_FFFF;
               4: v = 32'h8000_0000;
               5: v = 32'h0001_0000;
               default: v = 32'hFFFF_0000;
            endcase
         end
         default: begin
            // magnitude of random length, random sign
            v = v >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1)
               v = ~v + 1'b1;
         end
      endcase
      return v;
   endfunction

   // dividend sized against the divisor so the quotient mostly fits
   function automatic req_type fitting_pair();
      req_type           op;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] a;
      int                b_len;
      int                a_len;
      b_len = $urandom_range(1, 31);
      b     = ($urandom | 32'h1) >> (32 - b_len);
      b[b_len-1] = 1'b1;
      a_len = $urandom_range(0, (b_len + 15 > 31) ? 31 : b_len + 15);
      a     = (a_len == 0) ? '0 : ($urandom >> (32 - a_len));
      if ($urandom_range(0, 1) == 1) a = ~a + 1'b1;
      if ($urandom_range(0, 1) == 1) b = ~b + 1'b1;
      op.dividend = a;
      op.divisor  = b;
      return op;
   endfunction

   task automatic queue_word(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
      req_type op;
      op.dividend = a;
      op.divisor  = b;
      pending_words.push_back(op);
   endtask

   // ------------------------------------------------------------------------
   // driver: a new word goes out once the last one has been taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left != 0) begin
            // idle between bursts
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_words.size() != 0) begin
            req_word  <= pending_words.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               // about half the bursts run straight into the next
               gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result side stall, in segments of differing character
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(8, 96);
         rsp_stall  <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 9) < 8);
            STALL_TOGGLE: rsp_stall <= !rsp_stall;
            default:      rsp_stall <= 1'b0;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor: check leaving words, then predict for the word taken in
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quotients.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h %b %b",
                     $time, rsp_word.quotient, rsp_word.divide_by_zero, rsp_word.overflow);
            fail_count++;
         end else begin
            want = expected_quotients.pop_front();
            result_count++;
            if (want.divide_by_zero) zero_div_count++;
            if (want.overflow) overflow_count++;
            if (want.quotient[WORD_W-1]) negative_count++;
            if (rsp_word.quotient !== want.quotient) begin
               $display("%0t: quotient mismatch, expected %h, actual %h",
                        $time, want.quotient, rsp_word.quotient);
               fail_count++;
            end
            if (rsp_word.divide_by_zero !== want.divide_by_zero) begin
               $display("%0t: divide_by_zero mismatch, expected %b, actual %b",
                        $time, want.divide_by_zero, rsp_word.divide_by_zero);
               fail_count++;
            end
            if (rsp_word.overflow !== want.overflow) begin
               $display("%0t: overflow mismatch, expected %b, actual %b",
                        $time, want.overflow, rsp_word.overflow);
               fail_count++;
            end
         end
      end
      if (!reset && req_valid && !req_stall)
         expected_quotients.push_back(divide_q16(req_word));
   end

   // ------------------------------------------------------------------------
   // cycle limit
   // ------------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int pick;
      req_type op;

      // plain values and signs
      queue_word(32'h0000_0000, 32'h0001_0000);
      queue_word(32'h0001_0000, 32'h0001_0000);
      queue_word(32'hFFFF_0000, 32'h0001_0000);
      queue_word(32'h0001_0000, 32'hFFFF_0000);
      queue_word(32'hFFFF_0000, 32'hFFFF_0000);
      queue_word(32'h0007_0000, 32'h0002_0000);
      queue_word(32'h5555_5555, 32'h0003_0000);
      // truncation toward zero with mixed signs
      queue_word(32'hFFFF_FFFF, 32'h0000_0003);
      queue_word(32'h0000_0001, 32'hFFFD_0000);
      // extremes of both fields, most negative magnitude taken as 2^31
      queue_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_word(32'h8000_0000, 32'h8000_0000);
      queue_word(32'h8000_0000, 32'h7FFF_FFFF);
      queue_word(32'h7FFF_FFFF, 32'h8000_0000);
      queue_word(32'h0000_0001, 32'h8000_0000);
      queue_word(32'h7FFF_0000, 32'h0001_0000);
      // quotient of exactly 2^31, both sign combinations
      queue_word(32'h8000_0000, 32'h0001_0000);
      queue_word(32'h8000_0000, 32'hFFFF_0000);
      // oversized quotient wraps
      queue_word(32'h7FFF_FFFF, 32'h0000_0001);
      queue_word(32'h8000_0000, 32'h0000_0001);
      queue_word(32'h0001_0000, 32'hFFFF_FFFF);
      // zero divisor
      queue_word(32'h0000_0000, 32'h0000_0000);
      queue_word(32'h7FFF_FFFF, 32'h0000_0000);
      queue_word(32'h8000_0000, 32'h0000_0000);
      queue_word(32'hFFFF_0000, 32'h0000_0000);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            op = fitting_pair();
         end else begin
            op.dividend = random_operand();
            op.divisor  = (pick < 49) ? '0 : random_operand();
         end
         pending_words.push_back(op);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all words handed over, then every result back, then a quiet tail
      while (pending_words.size() != 0 || req_valid) @(negedge clock);
      while (expected_quotients.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);

      $display("checked %0d result words over %0d cycles", result_count, cycle_count);
      $display("zero divisors %0d, overflows %0d, negative quotients %0d",
               zero_div_count, overflow_count, negative_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
